[design/rbf_pkg.sv]
`timescale 1ns / 1ps

package rbf_pkg;

   localparam int DEPTH         = 1024;
   localparam int ADDR_BITS     = $clog2(DEPTH);
   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 11;
   localparam int OP_BITS       = 3;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 40;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_PEEK  = 3'd2,
      OP_INDEX = 3'd3,
      OP_SKIP  = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [SAMPLE_BITS-1:0] sample;
      logic [COUNT_BITS-1:0]  offset;
      logic [COUNT_BITS-1:0]  count;
   } req_type;

   typedef struct packed {
      logic                   we;
      logic                   re;
      logic [ADDR_BITS-1:0]   addr;
      logic [SAMPLE_BITS-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic                  ok;
      logic                  deliver;
      logic [COUNT_BITS-1:0] skipped;
      logic [COUNT_BITS-1:0] fill;
   } result_type;

endpackage

[design/rbf_mem.sv]
`timescale 1ns / 1ps

module rbf_mem (
   input  logic                            clock,
   input  rbf_pkg::mem_req_type            mem_req,
   output logic [rbf_pkg::SAMPLE_BITS-1:0] rdata
);

   logic [rbf_pkg::SAMPLE_BITS-1:0] store_ff [rbf_pkg::DEPTH];
   logic [rbf_pkg::SAMPLE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.addr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= store_ff[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/rbf_ctrl.sv]
`timescale 1ns / 1ps

module rbf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_accept,
   input  rbf_pkg::req_type               req,
   input  logic                           cfg_we,
   input  logic [rbf_pkg::COUNT_BITS-1:0] cfg_value,
   output rbf_pkg::mem_req_type           mem_req,
   output rbf_pkg::result_type            res,
   output logic [rbf_pkg::COUNT_BITS-1:0] capacity
);

   localparam int CB       = rbf_pkg::COUNT_BITS;
   localparam int AB       = rbf_pkg::ADDR_BITS;
   localparam int SUM_BITS = CB + 1;
   localparam logic [CB-1:0] CAP_MAX = CB'(rbf_pkg::DEPTH);
   localparam logic [CB-1:0] CAP_MIN = CB'(1);

   logic [AB-1:0] rpos_ff, rpos_in;
   logic [AB-1:0] wpos_ff, wpos_in;
   logic [CB-1:0] held_ff, held_in;
   logic [CB-1:0] cap_ff, cap_in;

   logic [SUM_BITS-1:0] rpos_ext, wpos_ext;
   logic                full, empty, off_neg;
   logic [CB-1:0]       back, skip_n;
   logic [AB-1:0]       fwd_addr, back_addr;

   // one conditional subtract is enough: neither operand exceeds capacity
   function automatic logic [AB-1:0] ring_wrap(input logic [SUM_BITS-1:0] sum,
                                               input logic [CB-1:0] cap);
      logic [SUM_BITS-1:0] s;
      s = (sum >= SUM_BITS'(cap)) ? sum - SUM_BITS'(cap) : sum;
      return s[AB-1:0];
   endfunction

   assign rpos_ext  = SUM_BITS'(rpos_ff);
   assign wpos_ext  = SUM_BITS'(wpos_ff);
   assign full      = (held_ff >= cap_ff);
   assign empty     = (held_ff == '0);
   assign off_neg   = req.offset[CB-1];
   assign back      = CB'(0) - req.offset;
   assign skip_n    = (req.count < held_ff) ? req.count : held_ff;
   assign fwd_addr  = ring_wrap(rpos_ext + SUM_BITS'(req.offset), cap_ff);
   assign back_addr = ring_wrap(wpos_ext + SUM_BITS'(cap_ff - back), cap_ff);

   always_comb begin
      rpos_in       = rpos_ff;
      wpos_in       = wpos_ff;
      held_in       = held_ff;
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.addr  = rpos_ff;
      mem_req.wdata = req.sample;
      res.ok        = 1'b0;
      res.deliver   = 1'b0;
      res.skipped   = '0;
      case (rbf_pkg::op_type'(req.op))
         rbf_pkg::OP_PUSH: begin
            mem_req.addr = wpos_ff;
            if (!full) begin
               mem_req.we = 1'b1;
               wpos_in    = ring_wrap(wpos_ext + SUM_BITS'(1), cap_ff);
               held_in    = held_ff + CB'(1);
               res.ok     = 1'b1;
            end
         end
         rbf_pkg::OP_POP, rbf_pkg::OP_PEEK: begin
            if (!empty) begin
               mem_req.re  = 1'b1;
               res.ok      = 1'b1;
               res.deliver = 1'b1;
               if (rbf_pkg::op_type'(req.op) == rbf_pkg::OP_POP) begin
                  rpos_in = ring_wrap(rpos_ext + SUM_BITS'(1), cap_ff);
                  held_in = held_ff - CB'(1);
               end
            end
         end
         rbf_pkg::OP_INDEX: begin
            if (!off_neg) begin
               mem_req.addr = fwd_addr;
               if (req.offset < held_ff) begin
                  mem_req.re  = 1'b1;
                  res.ok      = 1'b1;
                  res.deliver = 1'b1;
               end
            end else begin
               // negative offset counts back from the newest item
               mem_req.addr = back_addr;
               if (back <= held_ff) begin
                  mem_req.re  = 1'b1;
                  res.ok      = 1'b1;
                  res.deliver = 1'b1;
               end
            end
         end
         rbf_pkg::OP_SKIP: begin
            res.skipped = skip_n;
            rpos_in     = ring_wrap(rpos_ext + SUM_BITS'(skip_n), cap_ff);
            held_in     = held_ff - skip_n;
            res.ok      = 1'b1;
         end
         default: begin
         end
      endcase
      mem_req.we = mem_req.we & in_accept;
      mem_req.re = mem_req.re & in_accept;
      res.fill   = held_in;
   end

   always_comb begin
      if (cfg_value == '0) begin
         cap_in = CAP_MIN;
      end else if (cfg_value > CAP_MAX) begin
         cap_in = CAP_MAX;
      end else begin
         cap_in = cfg_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpos_ff <= '0;
         wpos_ff <= '0;
         held_ff <= '0;
         cap_ff  <= CAP_MAX;
      end else if (cfg_we) begin
         // a new capacity empties the ring
         rpos_ff <= '0;
         wpos_ff <= '0;
         held_ff <= '0;
         cap_ff  <= cap_in;
      end else if (in_accept) begin
         rpos_ff <= rpos_in;
         wpos_ff <= wpos_in;
         held_ff <= held_in;
      end
   end

   assign capacity = cap_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff)
      else $error("fill count above capacity");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (SUM_BITS'(rpos_ff) < SUM_BITS'(cap_ff)) && (SUM_BITS'(wpos_ff) < SUM_BITS'(cap_ff)))
      else $error("ring position outside capacity");

   a_pos_consistent: assert property (@(posedge clock) disable iff (reset)
      wpos_ff == ring_wrap(rpos_ext + SUM_BITS'(held_ff), cap_ff))
      else $error("write position does not match read position plus fill");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      in_accept && !cfg_we && (req.op == rbf_pkg::OP_PUSH) && (held_ff < cap_ff)
      |=> held_ff == $past(held_ff) + CB'(1))
      else $error("accepted push did not raise the fill count");
`endif

endmodule

[design/rbf_out.sv]
`timescale 1ns / 1ps

module rbf_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_accept,
   input  rbf_pkg::result_type             res,
   input  logic [rbf_pkg::SAMPLE_BITS-1:0] mem_rdata,
   input  logic                            out_ready,
   output logic                            in_ready,
   output logic                            out_valid,
   output logic                            out_ok,
   output logic [rbf_pkg::SAMPLE_BITS-1:0] out_sample,
   output logic [rbf_pkg::COUNT_BITS-1:0]  out_skipped,
   output logic [rbf_pkg::COUNT_BITS-1:0]  out_fill
);

   logic                            s1_valid_ff;
   rbf_pkg::result_type             s1_res_ff;
   logic                            out_valid_ff;
   logic                            out_ok_ff;
   logic [rbf_pkg::SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic [rbf_pkg::COUNT_BITS-1:0]  out_skipped_ff;
   logic [rbf_pkg::COUNT_BITS-1:0]  out_fill_ff;
   logic                            advance;

   // memory data is only refreshed on accept, so it stays put while stage 1 waits
   assign advance       = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready      = !s1_valid_ff || advance;
   assign out_sample_in = s1_res_ff.deliver ? mem_rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_res_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ok_ff      <= s1_res_ff.ok;
         out_sample_ff  <= out_sample_in;
         out_skipped_ff <= s1_res_ff.skipped;
         out_fill_ff    <= s1_res_ff.fill;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_ok      = out_ok_ff;
   assign out_sample  = out_sample_ff;
   assign out_skipped = out_skipped_ff;
   assign out_fill    = out_fill_ff;

`ifndef SYNTH
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> s1_valid_ff && out_valid_ff)
      else $error("input stalled with room in the pipe");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_res_ff))
      else $error("waiting item lost or changed in stage 1");
`endif

endmodule

[design/ring_buffer_fifo_top.sv]
`timescale 1ns / 1ps

// Ring FIFO of signed 16-bit samples with push, pop, peek, indexed read and skip.
// req channel: one operation per item; every accepted item yields exactly one
// rsp item, in order, carrying ok, the sample read (zero when none), the
// number of items skipped and the fill level after the operation.
// csr port: register 0 at byte address 0 is the ring capacity (1..1024, taken
// from the low 11 bits of the write data: 0 acts as 1, values above 1024 there
// clamp to 1024). Writing it empties the ring. Write it only while no item is in flight.
// Pipeline: the pointer update, the sample memory access and the stage 1
// result register all take an item at its accept edge; the registered memory
// read and stage 1 then feed the output register, which drives rsp.
// Throughput: one item per cycle while rsp_tready keeps up, set by the single
// memory port that each item uses at most once.
// Reset: pointers and fill count clear, capacity returns to 1024; the sample
// memory is not cleared, since entries are only read after being written.
// Stall: a waiting result is held in the output register while one more item
// can be taken into the stage behind it; after that req_tready drops until
// rsp_tready is seen.
module ring_buffer_fifo_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op[2:0], sample_in[18:3], offset[29:19], skip_count[40:30], zero fill
   input  logic [rbf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // ok[0], sample_out[16:1], skipped[27:17], fill_level[38:28], zero fill
   output logic [rbf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rbf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rbf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam logic REG_CAPACITY = 1'b0;
   localparam int   PAD_BITS     = rbf_pkg::RSP_DATA_BITS - 1 - rbf_pkg::SAMPLE_BITS
                                   - 2 * rbf_pkg::COUNT_BITS;

   rbf_pkg::req_type                req;
   rbf_pkg::mem_req_type            mem_req;
   rbf_pkg::result_type             res;
   logic [rbf_pkg::SAMPLE_BITS-1:0] mem_rdata;
   logic [rbf_pkg::COUNT_BITS-1:0]  capacity;
   logic                            in_accept;
   logic                            cfg_we;
   logic                            reg_sel;
   logic                            rsp_ok;
   logic [rbf_pkg::SAMPLE_BITS-1:0] rsp_sample;
   logic [rbf_pkg::COUNT_BITS-1:0]  rsp_skipped;
   logic [rbf_pkg::COUNT_BITS-1:0]  rsp_fill;

   assign req.op     = req_tdata[2:0];
   assign req.sample = req_tdata[18:3];
   assign req.offset = req_tdata[29:19];
   assign req.count  = req_tdata[40:30];

   assign in_accept  = req_tvalid && req_tready;
   assign reg_sel    = csr_paddr[2];
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_sel == REG_CAPACITY);
   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_sel == REG_CAPACITY) ? rbf_pkg::CSR_DATA_BITS'(capacity) : '0;

   rbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .req       (req),
      .cfg_we    (cfg_we),
      .cfg_value (csr_pwdata[rbf_pkg::COUNT_BITS-1:0]),
      .mem_req   (mem_req),
      .res       (res),
      .capacity  (capacity)
   );

   rbf_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   rbf_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .res         (res),
      .mem_rdata   (mem_rdata),
      .out_ready   (rsp_tready),
      .in_ready    (req_tready),
      .out_valid   (rsp_tvalid),
      .out_ok      (rsp_ok),
      .out_sample  (rsp_sample),
      .out_skipped (rsp_skipped),
      .out_fill    (rsp_fill)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, rsp_fill, rsp_skipped, rsp_sample, rsp_ok};

endmodule

[tb/sv/tb_ring_buffer_fifo_top.sv]
`timescale 1ns / 1ps

module tb_ring_buffer_fifo_top;

   localparam logic [rbf_pkg::CSR_ADDR_BITS-1:0] CAP_ADDR    = 3'd0;
   localparam logic [rbf_pkg::CSR_ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;
   localparam int FIRST_UNUSED_OP = 5;
   localparam int LAST_OP_CODE    = 7;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int REPORT_LIMIT    = 10;
   localparam int FILL_ITEMS      = 24;
   localparam int PHASE_ITEMS     = 50;

   typedef struct {
      logic [rbf_pkg::OP_BITS-1:0]     op;
      logic [rbf_pkg::SAMPLE_BITS-1:0] sample;
      logic [rbf_pkg::COUNT_BITS-1:0]  offset;
      logic [rbf_pkg::COUNT_BITS-1:0]  count;
   } op_item_type;

   typedef struct {
      logic                            ok;
      logic [rbf_pkg::SAMPLE_BITS-1:0] sample;
      logic [rbf_pkg::COUNT_BITS-1:0]  skipped;
      logic [rbf_pkg::COUNT_BITS-1:0]  fill;
   } fifo_result_type;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [rbf_pkg::REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [rbf_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [rbf_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [rbf_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [rbf_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   // shadow copy of the ring
   logic [rbf_pkg::SAMPLE_BITS-1:0] ring_mem [rbf_pkg::DEPTH];
   int ring_cap  = rbf_pkg::DEPTH;
   int ring_rd   = 0;
   int ring_wr   = 0;
   int ring_held = 0;

   op_item_type     pending_ops[$];
   fifo_result_type expected_results[$];
   int error_count  = 0;
   int idle_pct     = 0;
   int req_gap      = 0;
   int rsp_stall    = 0;
   int sent_count   = 0;
   int accept_count = 0;

   ring_buffer_fifo_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int ring_step(input int pos, input int n);
      int s;
      s = pos + n;
      if (s >= ring_cap) begin
         s -= ring_cap;
      end
      return s;
   endfunction

   function automatic void apply_config(input logic [rbf_pkg::CSR_ADDR_BITS-1:0] addr,
                                        input logic [rbf_pkg::CSR_DATA_BITS-1:0] data);
      int v;
      if (addr == CAP_ADDR) begin
         v = int'(data[rbf_pkg::COUNT_BITS-1:0]);
         if (v < 1) begin
            v = 1;
         end
         if (v > rbf_pkg::DEPTH) begin
            v = rbf_pkg::DEPTH;
         end
         ring_cap  = v;
         ring_rd   = 0;
         ring_wr   = 0;
         ring_held = 0;
      end
   endfunction

   function automatic fifo_result_type predict_fifo_result(input op_item_type it);
      fifo_result_type r;
      int back;
      int n;
      r.ok      = 1'b0;
      r.sample  = '0;
      r.skipped = '0;
      case (it.op)
         rbf_pkg::OP_PUSH: begin
            if (ring_held < ring_cap) begin
               ring_mem[ring_wr] = it.sample;
               ring_wr = ring_step(ring_wr, 1);
               ring_held++;
               r.ok = 1'b1;
            end
         end
         rbf_pkg::OP_POP, rbf_pkg::OP_PEEK: begin
            if (ring_held != 0) begin
               r.sample = ring_mem[ring_rd];
               r.ok = 1'b1;
               if (it.op == rbf_pkg::OP_POP) begin
                  ring_rd = ring_step(ring_rd, 1);
                  ring_held--;
               end
            end
         end
         rbf_pkg::OP_INDEX: begin
            if (!it.offset[rbf_pkg::COUNT_BITS-1]) begin
               if (int'(it.offset) < ring_held) begin
                  r.sample = ring_mem[ring_step(ring_rd, int'(it.offset))];
                  r.ok = 1'b1;
               end
            end else begin
               // negative offset counts back from the newest item
               back = (1 << rbf_pkg::COUNT_BITS) - int'(it.offset);
               if (back <= ring_held) begin
                  r.sample = ring_mem[ring_step(ring_wr, ring_cap - back)];
                  r.ok = 1'b1;
               end
            end
         end
         rbf_pkg::OP_SKIP: begin
            n = (int'(it.count) < ring_held) ? int'(it.count) : ring_held;
            ring_rd = ring_step(ring_rd, n);
            ring_held -= n;
            r.skipped = rbf_pkg::COUNT_BITS'(n);
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      r.fill = rbf_pkg::COUNT_BITS'(ring_held);
      return r;
   endfunction

   task automatic add_op(input int op_code, input int s, input int off, input int cnt);
      op_item_type it;
      it.op     = op_code[rbf_pkg::OP_BITS-1:0];
      it.sample = s[rbf_pkg::SAMPLE_BITS-1:0];
      it.offset = off[rbf_pkg::COUNT_BITS-1:0];
      it.count  = cnt[rbf_pkg::COUNT_BITS-1:0];
      pending_ops.push_back(it);
   endtask

   task automatic csr_write(input logic [rbf_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [rbf_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   task automatic flag_mismatch(input string field_name, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected %0d, got %0d at %0t", field_name, want, got, $time);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      op_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || accept_count == sent_count) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            it = pending_ops.pop_front();
            req_tdata  <= rbf_pkg::REQ_DATA_BITS'({it.count, it.offset, it.sample, it.op});
            req_tvalid <= 1'b1;
            sent_count++;
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
               req_gap = $urandom_range(1, 9);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall = $urandom_range(1, 9);
         end
      end
   end

   // monitor: follow register writes, predict on accepted requests, check results
   always @(posedge clock) begin
      op_item_type     acc;
      fifo_result_type want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            apply_config(csr_paddr, csr_pwdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("unexpected rsp item 0x%h at %0t", rsp_tdata, $time);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.ok) begin
                  flag_mismatch("ok", int'(want.ok), int'(rsp_tdata[0]));
               end
               if (rsp_tdata[16:1] !== want.sample) begin
                  flag_mismatch("sample_out", int'($signed(want.sample)),
                                int'($signed(rsp_tdata[16:1])));
               end
               if (rsp_tdata[27:17] !== want.skipped) begin
                  flag_mismatch("skipped", int'(want.skipped), int'(rsp_tdata[27:17]));
               end
               if (rsp_tdata[38:28] !== want.fill) begin
                  flag_mismatch("fill_level", int'(want.fill), int'(rsp_tdata[38:28]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            acc.op     = req_tdata[2:0];
            acc.sample = req_tdata[18:3];
            acc.offset = req_tdata[29:19];
            acc.count  = req_tdata[40:30];
            expected_results.push_back(predict_fifo_result(acc));
            accept_count++;
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int phase;
      int n;
      int pick;
      int span;
      int push_pct;
      int op_code;
      int smp;
      int off;
      int cnt;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      idle_pct = 15;

      // empty ring at reset capacity
      add_op(rbf_pkg::OP_POP, $urandom, $urandom, $urandom);
      add_op(rbf_pkg::OP_PEEK, $urandom, $urandom, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, 0, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, -1, $urandom);
      add_op(rbf_pkg::OP_SKIP, $urandom, $urandom, 5);
      // sample extremes
      add_op(rbf_pkg::OP_PUSH, 16'sh7FFF, $urandom, $urandom);
      add_op(rbf_pkg::OP_PUSH, 16'sh8000, $urandom, $urandom);
      add_op(rbf_pkg::OP_PUSH, 16'h0000, $urandom, $urandom);
      add_op(rbf_pkg::OP_PUSH, 16'hFFFF, $urandom, $urandom);
      add_op(rbf_pkg::OP_PEEK, $urandom, $urandom, $urandom);
      // indexed reads at and past both ends of the fill level, then unused op codes, pops and skips
      add_op(rbf_pkg::OP_INDEX, $urandom, 0, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, 3, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, 4, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, -1, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, -4, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, -5, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, -rbf_pkg::DEPTH, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, rbf_pkg::DEPTH - 1, $urandom);
      add_op(FIRST_UNUSED_OP, $urandom, $urandom, $urandom);
      add_op(LAST_OP_CODE, $urandom, $urandom, $urandom);
      add_op(rbf_pkg::OP_POP, $urandom, $urandom, $urandom);
      add_op(rbf_pkg::OP_SKIP, $urandom, $urandom, 0);
      add_op(rbf_pkg::OP_SKIP, $urandom, $urandom, rbf_pkg::DEPTH);
      add_op(rbf_pkg::OP_POP, $urandom, $urandom, $urandom);
      wait_drained();

      // all-ones write clamps to full depth; partial fill, reads at both ends, flush
      csr_write(CAP_ADDR, 32'h0000_07FF);
      @(posedge clock);
      for (n = 0; n < FILL_ITEMS; n++) begin
         add_op(rbf_pkg::OP_PUSH, $urandom, $urandom, $urandom);
      end
      for (n = 0; n < 3; n++) begin
         add_op(rbf_pkg::OP_POP, $urandom, $urandom, $urandom);
      end
      for (n = 0; n < 3; n++) begin
         add_op(rbf_pkg::OP_PUSH, $urandom, $urandom, $urandom);
      end
      add_op(rbf_pkg::OP_INDEX, $urandom, -1, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, 0, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, rbf_pkg::DEPTH - 1, $urandom);
      add_op(rbf_pkg::OP_INDEX, $urandom, -rbf_pkg::DEPTH, $urandom);
      add_op(rbf_pkg::OP_SKIP, $urandom, $urandom, rbf_pkg::DEPTH);
      add_op(rbf_pkg::OP_INDEX, $urandom, 0, $urandom);

      for (phase = 0; phase < 9; phase++) begin
         wait_drained();
         idle_pct = (phase == 2 || phase == 8) ? 0 : 20;
         push_pct = (phase % 2) ? 30 : 45;
         case (phase)
            0: csr_write(CAP_ADDR, 1);
            1: csr_write(CAP_ADDR, 2);
            2: csr_write(CAP_ADDR, 0);
            3: csr_write(CAP_ADDR, $urandom_range(3, 16));
            // ignored register; the ring keeps its items
            4: csr_write(UNUSED_ADDR, $urandom);
            5: csr_write(CAP_ADDR, 32'hFFFF_F805);
            6: csr_write(CAP_ADDR, $urandom_range(17, 300));
            7: csr_write(CAP_ADDR, rbf_pkg::DEPTH);
            default: csr_write(CAP_ADDR, rbf_pkg::DEPTH + 1);
         endcase
         @(posedge clock);
         span = (ring_cap < 24) ? ring_cap : 24;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            smp  = $urandom;
            off  = $urandom;
            cnt  = $urandom_range(0, rbf_pkg::DEPTH);
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
               op_code = rbf_pkg::OP_PUSH;
            end else if (pick < push_pct + 20) begin
               op_code = rbf_pkg::OP_POP;
            end else if (pick < push_pct + 30) begin
               op_code = rbf_pkg::OP_PEEK;
            end else if (pick < push_pct + 48) begin
               op_code = rbf_pkg::OP_INDEX;
               // mostly offsets within span of the oldest or the newest item, both signs
               if ($urandom_range(0, 9) != 0) begin
                  off = int'($urandom_range(0, 2 * span + 1)) - span - 1;
               end
            end else if (pick < 97) begin
               op_code = rbf_pkg::OP_SKIP;
               if ($urandom_range(0, 4) != 0) begin
                  cnt = $urandom_range(0, span / 4 + 1);
               end
            end else begin
               op_code = $urandom_range(FIRST_UNUSED_OP, LAST_OP_CODE);
            end
            add_op(op_code, smp, off, cnt);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[ring_buffer_fifo_top.f]
design/rbf_pkg.sv
design/rbf_mem.sv
design/rbf_ctrl.sv
design/rbf_out.sv
design/ring_buffer_fifo_top.sv
tb/sv/tb_ring_buffer_fifo_top.sv
